/* rtl/rrtm_pkg.sv */
// Package for the RR trimmed-mean heart rate block.
// Holds window sizing, divider widths, output codes and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package rrtm_pkg;

	localparam int WINDOW_LEN = 8;

	localparam int IV_W    = 16;
	localparam int SUM_W   = $clog2(WINDOW_LEN * 65535 + 1);
	localparam int NUM_VAL = 60000 * (WINDOW_LEN - 4);
	localparam int NUM_W   = $clog2(NUM_VAL + 1);
	localparam int IDX_W   = $clog2(WINDOW_LEN);
	localparam int FILL_W  = $clog2(WINDOW_LEN + 1);
	localparam int DCNT_W  = $clog2(NUM_W);
	localparam int RATE_W  = 11;

	localparam logic [IV_W-1:0]       IV_MAX     = '1;
	localparam logic [RATE_W-1:0]     RATE_MAX   = 11'd1023;
	localparam logic signed [31:0]    MARK_LEAD  = 32'sd1000;
	localparam logic signed [2:0]     KIND_RATE  = 3'sd2;
	localparam logic signed [1:0]     FLAG_RATE  = 2'sd1;

	typedef struct packed {
		logic load;
		logic eval;
		logic scan;
		logic trim;
		logic div;
		logic write;
	} rrtm_cmd_t;

	typedef struct packed {
		logic compute;
		logic scan_last;
		logic div_last;
		logic out_free;
	} rrtm_sts_t;

endpackage

/* rtl/rrtm_ctrl.sv */
// Controller for the RR trimmed-mean heart rate block.
// Sequences accept, update, window scan, trim, divide and result write.
// Depends on rrtm_pkg.
`timescale 1ns / 1ps

module rrtm_ctrl
	import rrtm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  rrtm_sts_t sts,
	output rrtm_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SCAN,
		ST_TRIM,
		ST_DIV,
		ST_WRITE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= sts.compute ? ST_SCAN : ST_WRITE;
				end
				ST_SCAN: begin
					if (sts.scan_last) state_q <= ST_TRIM;
				end
				ST_TRIM: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (sts.div_last) state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign cmd.load  = (state_q == ST_IDLE) && s_tvalid;
	assign cmd.eval  = (state_q == ST_EVAL);
	assign cmd.scan  = (state_q == ST_SCAN);
	assign cmd.trim  = (state_q == ST_TRIM);
	assign cmd.div   = (state_q == ST_DIV);
	assign cmd.write = (state_q == ST_WRITE) && sts.out_free;

endmodule

/* rtl/rrtm_dp.sv */
// Datapath for the RR trimmed-mean heart rate block.
// Holds peak state, interval window, scan extremes, bit-serial divider and result register.
// Depends on rrtm_pkg; driven by rrtm_ctrl commands.
`timescale 1ns / 1ps

module rrtm_dp
	import rrtm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  rrtm_cmd_t                cmd,
	output rrtm_sts_t                sts,
	input  logic signed [31:0]       r_location,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [31:0]       mark_start,
	output logic signed [31:0]       mark_end,
	output logic signed [2:0]        mark_kind,
	output logic signed [1:0]        mark_flag,
	output logic signed [RATE_W-1:0] heart_rate
);

	logic signed [31:0] in_q;
	logic signed [31:0] prev_q;
	logic [FILL_W-1:0]  fill_q;
	logic [IV_W-1:0]    win_q [WINDOW_LEN];
	logic               rate_valid_q;

	logic [IDX_W-1:0]   idx_q;
	logic [SUM_W-1:0]   total_q;
	logic [IV_W-1:0]    max1_q, max2_q, min1_q, min2_q;
	logic [SUM_W-1:0]   trim_q;
	logic [SUM_W-1:0]   rem_q;
	logic [NUM_W-1:0]   dq_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic               out_valid_q;

	logic               pos;
	logic               full;
	logic signed [32:0] diff;
	logic [IV_W-1:0]    iv;
	logic [IV_W-1:0]    v;
	logic [SUM_W:0]     trial;
	logic               ge;
	logic [RATE_W-1:0]  rate;

	assign pos  = !in_q[31] && (in_q != 32'sd0);
	assign full = (fill_q == FILL_W'(WINDOW_LEN));
	assign diff = {in_q[31], in_q} - {prev_q[31], prev_q};

	always_comb begin
		if (diff[32]) begin
			iv = '0;
		end else if (diff[31:IV_W] != '0) begin
			iv = IV_MAX;
		end else begin
			iv = diff[IV_W-1:0];
		end
	end

	assign v     = win_q[idx_q];
	assign trial = {rem_q, dq_q[NUM_W-1]};
	assign ge    = (trial >= {1'b0, trim_q});

	assign rate = ((trim_q == '0) || (dq_q > NUM_W'(RATE_MAX))) ? RATE_MAX
	            : dq_q[RATE_W-1:0];

	assign sts.compute   = pos && full;
	assign sts.scan_last = (idx_q == IDX_W'(WINDOW_LEN - 1));
	assign sts.div_last  = (dcnt_q == DCNT_W'(NUM_W - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= r_location;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q       <= '0;
			fill_q       <= '0;
			rate_valid_q <= 1'b0;
		end else if (cmd.eval) begin
			rate_valid_q <= pos && full;
			if (pos) begin
				prev_q <= in_q;
				if (!full) fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval && pos && (fill_q != '0)) begin
			for (int i = 0; i < WINDOW_LEN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WINDOW_LEN-1] <= iv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			total_q <= '0;
			max1_q  <= '0;
			max2_q  <= '0;
			min1_q  <= '1;
			min2_q  <= '1;
		end else if (cmd.eval) begin
			idx_q   <= '0;
			total_q <= '0;
			max1_q  <= '0;
			max2_q  <= '0;
			min1_q  <= '1;
			min2_q  <= '1;
		end else if (cmd.scan) begin
			idx_q   <= idx_q + IDX_W'(1);
			total_q <= total_q + SUM_W'(v);
			if (v > max1_q) begin
				max2_q <= max1_q;
				max1_q <= v;
			end else if (v > max2_q) begin
				max2_q <= v;
			end
			if (v < min1_q) begin
				min2_q <= min1_q;
				min1_q <= v;
			end else if (v < min2_q) begin
				min2_q <= v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.trim) begin
			trim_q <= total_q - SUM_W'(max1_q) - SUM_W'(max2_q)
			        - SUM_W'(min1_q) - SUM_W'(min2_q);
			rem_q  <= '0;
			dq_q   <= NUM_W'(NUM_VAL);
			dcnt_q <= '0;
		end else if (cmd.div) begin
			rem_q  <= ge ? SUM_W'(trial - {1'b0, trim_q}) : trial[SUM_W-1:0];
			dq_q   <= {dq_q[NUM_W-2:0], ge};
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.write) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			if (rate_valid_q) begin
				mark_start <= in_q - MARK_LEAD;
				mark_end   <= in_q;
				mark_kind  <= KIND_RATE;
				mark_flag  <= FLAG_RATE;
				heart_rate <= rate;
			end else begin
				mark_start <= '1;
				mark_end   <= '1;
				mark_kind  <= '1;
				mark_flag  <= '1;
				heart_rate <= '1;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_LEN))
		else $error("fill count beyond window length");

	a_max_order: assert property (@(posedge clk) disable iff (!arst_n)
		max1_q >= max2_q)
		else $error("largest pair out of order");

	a_min_order: assert property (@(posedge clk) disable iff (!arst_n)
		min1_q <= min2_q)
		else $error("smallest pair out of order");

	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> (!out_valid_q || out_ready))
		else $error("result written over an untaken word");
`endif

endmodule

/* rtl/rr_trimmed_mean_heart_rate_top.sv */
// Channel   Dir  Bits    Contents
// s_*       in   32      tdata: r_location
// m_*       out  80 + 8  tdata: mark_start, mark_end, heart_rate; tuser: mark_kind, mark_flag
//
// An item that gives no rate passes accept, evaluate and result write; a rate item also
// passes the window scan, the trim and the one-bit-a-cycle divider before the result write.
// One item is in work at a time.
// arst_n clears the controller, peak state and fill count; no clearing pass is run.
// A stalled result holds in the output register while the next word is accepted.
`timescale 1ns / 1ps

module rr_trimmed_mean_heart_rate_top
	import rrtm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // r_location[31:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // mark_start[31:0], mark_end[63:32], heart_rate[74:64],
	                              // zero[79:75]
	output logic [7:0]  m_tuser   // mark_kind[2:0], mark_flag[4:3], zero[7:5]
);

	rrtm_cmd_t                cmd;
	rrtm_sts_t                sts;
	logic signed [31:0]       mark_start;
	logic signed [31:0]       mark_end;
	logic signed [2:0]        mark_kind;
	logic signed [1:0]        mark_flag;
	logic signed [RATE_W-1:0] heart_rate;

	rrtm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rrtm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.r_location (s_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.mark_start (mark_start),
		.mark_end   (mark_end),
		.mark_kind  (mark_kind),
		.mark_flag  (mark_flag),
		.heart_rate (heart_rate)
	);

	assign m_tdata = {5'b0, heart_rate, mark_end, mark_start};
	assign m_tuser = {3'b0, mark_flag, mark_kind};

endmodule

/* tb/testbench.sv */
// Self-checking bench for rr_trimmed_mean_heart_rate_top: R-peak words in, one mark word out.
// Predicts each mark from a local copy of the RR window and checks it field by field.
// Depends on rrtm_pkg and the top level RTL only.
`timescale 1ns / 1ps

module testbench;
	import rrtm_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic signed [RATE_W-1:0] heart_rate;
		logic signed [1:0]        mark_flag;
		logic signed [2:0]        mark_kind;
		logic signed [31:0]       mark_end;
		logic signed [31:0]       mark_start;
	} mark_word_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // r_location[31:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;   // mark_start, mark_end, heart_rate
	logic [7:0]  m_tuser;   // mark_kind, mark_flag

	// predictor state
	int                peaks_seen;
	logic signed [31:0] last_peak;
	logic [IV_W-1:0]   rr_window [WINDOW_LEN];

	mark_word_t pending_marks [$];
	int mismatches = 0;
	int marks_checked = 0;
	int rates_checked = 0;
	int peaks_sent;
	int cycle_count = 0;

	logic               steady;
	int                 holds_asked;
	int                 holds_served = 0;
	int                 hold_left = 0;
	int                 stall_left = 0;
	logic signed [31:0] beat_time;

	rr_trimmed_mean_heart_rate_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int rand_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 88)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic mark_word_t predict_mark(input logic signed [31:0] r);
		mark_word_t         w;
		logic signed [32:0] diff;
		logic [IV_W-1:0]    iv;
		logic [IV_W-1:0]    s [WINDOW_LEN];
		logic [IV_W-1:0]    v;
		logic [31:0]        sum;
		logic [31:0]        rate;
		int                 i;
		int                 j;
		w = '1;
		if (r <= 0)
			return w;
		if (peaks_seen == 0) begin
			last_peak = r;
			peaks_seen = 1;
			return w;
		end
		diff = 33'(r) - 33'(last_peak);
		if (diff < 0)
			iv = '0;
		else if (diff > 33'sd65535)
			iv = IV_MAX;
		else
			iv = diff[IV_W-1:0];
		last_peak = r;
		if (peaks_seen < WINDOW_LEN) begin
			rr_window[peaks_seen-1] = iv;
			peaks_seen++;
			return w;
		end
		rr_window[WINDOW_LEN-1] = iv;
		s = rr_window;
		for (i = 1; i < WINDOW_LEN; i++) begin
			v = s[i];
			j = i - 1;
			while (j >= 0 && s[j] > v) begin
				s[j+1] = s[j];
				j--;
			end
			s[j+1] = v;
		end
		sum = 0;
		for (i = 2; i < WINDOW_LEN - 2; i++)
			sum += 32'(s[i]);
		if (sum == 0)
			rate = 32'(RATE_MAX);
		else begin
			rate = NUM_VAL / sum;
			if (rate > 32'(RATE_MAX))
				rate = 32'(RATE_MAX);
		end
		for (i = 1; i < WINDOW_LEN; i++)
			rr_window[i-1] = rr_window[i];
		w.mark_start = r - MARK_LEAD;
		w.mark_end   = r;
		w.mark_kind  = KIND_RATE;
		w.mark_flag  = FLAG_RATE;
		w.heart_rate = rate[RATE_W-1:0];
		return w;
	endfunction

	task automatic send_peak(input logic signed [31:0] r);
		int gap;
		gap = steady ? 0 : rand_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= r;
		do @(posedge clk); while (!s_tready);
		pending_marks = {pending_marks, predict_mark(r)};
		peaks_sent++;
		@(negedge clk);
	endtask

	// ignored words, zero intervals, saturated and backward intervals, a plain rhythm
	task automatic test_directed();
		logic signed [31:0] peaks [25];
		int i;
		peaks = '{32'sh80000000, 0, -1, 1, 1, 1, 1, 1, -7, 1, 1, 1, 1,
			32'sh7FFFFFFF, 100, 32'sh7FFFFFFF, 1000, 1800, 2600, 3400, 4200,
			5000, 5800, 6610, 7400};
		for (i = 0; i < 25; i++)
			send_peak(peaks[i]);
		beat_time = 7400;
	endtask

	task automatic test_random_rhythm(input int count);
		int k;
		int p;
		int base;
		int spread;
		int jitter;
		logic signed [31:0] r;
		base = 800;
		spread = 100;
		for (k = 0; k < count; k++) begin
			if (k % 40 == 0) begin
				p = $urandom_range(0, 9);
				if (p == 0)
					base = $urandom_range(1, 60);
				else if (p == 1)
					base = $urandom_range(30000, 65535);
				else
					base = $urandom_range(250, 2000);
				spread = base / 4;
				if ($urandom_range(0, 1))
					beat_time = $urandom_range(1, 2140000000);
			end
			if (beat_time > 32'sd2140000000 || beat_time <= 0)
				beat_time = $urandom_range(1, 1000);
			p = $urandom_range(0, 99);
			if (p < 88) begin
				jitter = $urandom_range(0, 2 * spread);
				beat_time = beat_time + base + jitter - spread;
				r = beat_time;
			end else if (p < 92)
				r = $urandom;
			else if (p < 95)
				r = $urandom_range(0, 1) ? 32'sd0 : {1'b1, 31'($urandom)};
			else if (p < 98) begin
				r = beat_time - $urandom_range(1, 5000);
				if (r <= 0)
					r = 1;
			end else begin
				beat_time = beat_time + $urandom_range(65536, 10000000);
				r = beat_time;
			end
			send_peak(r);
		end
	endtask

	// hold the receiver off while the sender keeps offering words
	task automatic test_backpressure();
		int k;
		steady = 1'b1;
		holds_asked++;
		for (k = 0; k < 24; k++) begin
			beat_time = beat_time + $urandom_range(400, 1400);
			send_peak(beat_time);
		end
		steady = 1'b0;
	endtask

	task automatic test_steady_stream(input int count);
		int k;
		steady = 1'b1;
		for (k = 0; k < count; k++) begin
			beat_time = beat_time + $urandom_range(500, 1200);
			send_peak(beat_time);
		end
		steady = 1'b0;
	endtask

	always @(negedge clk) begin
		if (holds_served != holds_asked) begin
			holds_served <= holds_served + 1;
			hold_left    <= HOLD_CYCLES;
			m_tready     <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (steady)
			m_tready <= 1'b1;
		else if ($urandom_range(0, 7) == 0) begin
			stall_left <= rand_gap();
			m_tready   <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		mark_word_t got;
		mark_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.mark_start = m_tdata[31:0];
			got.mark_end   = m_tdata[63:32];
			got.heart_rate = m_tdata[74:64];
			got.mark_kind  = m_tuser[2:0];
			got.mark_flag  = m_tuser[4:3];
			if (pending_marks.size() == 0) begin
				$error("unexpected mark word %h user %h", m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = pending_marks.pop_front();
				marks_checked++;
				if (want.mark_kind == KIND_RATE)
					rates_checked++;
				if (got.mark_start !== want.mark_start) begin
					$error("mark_start expected %0d got %0d", want.mark_start, got.mark_start);
					mismatches++;
				end
				if (got.mark_end !== want.mark_end) begin
					$error("mark_end expected %0d got %0d", want.mark_end, got.mark_end);
					mismatches++;
				end
				if (got.mark_kind !== want.mark_kind) begin
					$error("mark_kind expected %0d got %0d", want.mark_kind, got.mark_kind);
					mismatches++;
				end
				if (got.mark_flag !== want.mark_flag) begin
					$error("mark_flag expected %0d got %0d", want.mark_flag, got.mark_flag);
					mismatches++;
				end
				if (got.heart_rate !== want.heart_rate) begin
					$error("heart_rate expected %0d got %0d", want.heart_rate,
						got.heart_rate);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		steady       = 1'b0;
		holds_asked  = 0;
		peaks_seen   = 0;
		last_peak    = '0;
		beat_time    = 0;
		peaks_sent   = 0;
		foreach (rr_window[i])
			rr_window[i] = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_rhythm(1150);
		test_backpressure();
		test_steady_stream(150);

		s_tvalid <= 1'b0;
		while (pending_marks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d R-peak words; checked %0d mark words, %0d carrying a heart rate.",
			peaks_sent, marks_checked, rates_checked);
		$display("Covered ignored and backward peaks, saturated intervals, zero sums %s",
			"and a long output stall.");
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
